// ===== design/rofd_pkg.sv =====
// shared types, constants and codes of the radar object frame decoder
package rofd_pkg;

   localparam int OBJECT_SLOTS   = 256;
   localparam int SLOT_BITS      = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [10:0] ID_GENERAL  = 11'd1547;
   localparam logic [10:0] ID_QUALITY  = 11'd1548;
   localparam logic [10:0] ID_EXTENDED = 11'd1549;

   typedef struct packed {
      logic [10:0] frame_ident;
      logic [7:0]  byte_0;
      logic [7:0]  byte_1;
      logic [7:0]  byte_2;
      logic [7:0]  byte_3;
      logic [7:0]  byte_4;
      logic [7:0]  byte_5;
      logic [7:0]  byte_6;
      logic [7:0]  byte_7;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  object_number;
      logic [12:0] dist_long_code;
      logic [10:0] dist_lat_code;
      logic [9:0]  vel_long_code;
      logic [8:0]  vel_lat_code;
      logic [7:0]  rcs_code;
      logic [2:0]  meas_status;
      logic [2:0]  object_class;
      logic [9:0]  orient_code;
      logic [7:0]  length_code;
      logic [7:0]  width_code;
   } rsp_word_type;

   typedef struct packed {
      logic [12:0] dist_long;
      logic [10:0] dist_lat;
      logic [9:0]  vel_long;
      logic [8:0]  vel_lat;
      logic [7:0]  rcs;
   } kin_entry_type;

   localparam int KIN_BITS = $bits(kin_entry_type);

   typedef enum logic [1:0] {
      CMD_GENERAL,
      CMD_QUALITY,
      CMD_EXTENDED
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type  kind;
      logic          slot_ok;
      logic [7:0]    object_number;
      kin_entry_type kin;
      logic [2:0]    meas;
      logic [2:0]    object_class;
      logic [9:0]    orient_code;
      logic [7:0]    length_code;
      logic [7:0]    width_code;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_READ,
      BACK_SEND,
      BACK_CLEAR
   } back_state_type;

endpackage

// ===== design/rofd_ram.sv =====
// generic single-write, single-read ram with registered read data
module rofd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rofd_front.sv =====
// front end: classifies incoming frames and unpacks them into queue commands
module rofd_front import rofd_pkg::*; (
   input  logic             req_valid,
   input  req_word_type     req_word,
   input  queue_status_type q_stat,
   output logic             req_stall,
   output logic             push,
   output cmd_type          cmd
);

   logic known;

   // measurement state bit tree; b4 set with b1 set has no listed meaning
   function automatic logic [2:0] qual_decode(input logic [7:0] b);
      logic [2:0] ms;
      if (!b[4]) begin
         if (!b[3]) ms = b[2] ? 3'd1 : 3'd0;
         else       ms = b[0] ? 3'd3 : 3'd2;
      end else if (!b[1]) begin
         ms = b[0] ? 3'd5 : 3'd4;
      end else begin
         ms = 3'd0;
      end
      return ms;
   endfunction

   always_comb begin
      known    = 1'b1;
      cmd.kind = CMD_GENERAL;
      unique case (req_word.frame_ident)
         ID_GENERAL:  cmd.kind = CMD_GENERAL;
         ID_QUALITY:  cmd.kind = CMD_QUALITY;
         ID_EXTENDED: cmd.kind = CMD_EXTENDED;
         default:     known = 1'b0;
      endcase

      cmd.slot_ok       = (9'(req_word.byte_0) < 9'(OBJECT_SLOTS));
      cmd.object_number = req_word.byte_0;

      cmd.kin.dist_long = {req_word.byte_1, req_word.byte_2[7:3]};
      cmd.kin.dist_lat  = {req_word.byte_2[2:0], req_word.byte_3};
      cmd.kin.vel_long  = {req_word.byte_4, req_word.byte_5[7:6]};
      cmd.kin.vel_lat   = {req_word.byte_5[5:0], req_word.byte_6[7:5]};
      cmd.kin.rcs       = req_word.byte_7;

      cmd.meas          = qual_decode(req_word.byte_6);

      cmd.object_class  = req_word.byte_3[2:0];
      cmd.orient_code   = {req_word.byte_4, req_word.byte_5[7:6]};
      cmd.length_code   = req_word.byte_6;
      cmd.width_code    = req_word.byte_7;
   end

   // unknown identifiers are taken and dropped here
   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full && known;

endmodule

// ===== design/rofd_queue.sv =====
// small command queue between the front end and the table back end
module rofd_queue import rofd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          cmd_in,
   input  logic             pop,
   output cmd_type          cmd_out,
   output queue_status_type q_stat
);

   cmd_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   assign cmd_out      = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

// ===== design/rofd_back.sv =====
// back end: writes the object tables and builds the joined result word
module rofd_back import rofd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_stat,
   input  cmd_type          head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_word
);

   back_state_type          state_ff, state_in;
   logic [SLOT_BITS-1:0]    clr_ff, clr_in;
   logic                    slot_ok_ff;
   cmd_type                 hold_ff;
   rsp_word_type            rsp_ff;

   logic                    kin_we, meas_we, rd_en, clearing;
   logic [SLOT_BITS-1:0]    slot, wr_slot;
   logic [KIN_BITS-1:0]     kin_rd_bits, kin_wr_bits;
   logic [2:0]              meas_rd, meas_wr;
   kin_entry_type           kin_rd;

   assign slot        = head.object_number[SLOT_BITS-1:0];
   assign clearing    = (state_ff == BACK_CLEAR);
   // zeroing pass after reset walks every slot once
   assign wr_slot     = clearing ? clr_ff : slot;
   assign kin_wr_bits = clearing ? '0 : head.kin;
   assign meas_wr     = clearing ? 3'd0 : head.meas;
   assign clr_in      = clearing ? clr_ff + 1'b1 : clr_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: if (!q_stat.empty && head.kind == CMD_EXTENDED) state_in = BACK_READ;
         BACK_READ: state_in = BACK_SEND;
         BACK_SEND: if (!rsp_stall) state_in = BACK_IDLE;
         BACK_CLEAR: if (clr_ff == SLOT_BITS'(OBJECT_SLOTS - 1)) state_in = BACK_IDLE;
         default:   state_in = BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop       = 1'b0;
      kin_we    = 1'b0;
      meas_we   = 1'b0;
      rd_en     = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            pop     = !q_stat.empty;
            kin_we  = !q_stat.empty && head.kind == CMD_GENERAL && head.slot_ok;
            meas_we = !q_stat.empty && head.kind == CMD_QUALITY && head.slot_ok;
            rd_en   = !q_stat.empty && head.kind == CMD_EXTENDED;
         end
         BACK_READ: ;
         BACK_SEND: rsp_valid = 1'b1;
         BACK_CLEAR: begin
            kin_we  = 1'b1;
            meas_we = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // a slot beyond the tables reads as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         hold_ff    <= head;
         slot_ok_ff <= head.slot_ok;
      end
      if (state_ff == BACK_READ) begin
         rsp_ff.object_number  <= hold_ff.object_number;
         rsp_ff.dist_long_code <= slot_ok_ff ? kin_rd.dist_long : '0;
         rsp_ff.dist_lat_code  <= slot_ok_ff ? kin_rd.dist_lat : '0;
         rsp_ff.vel_long_code  <= slot_ok_ff ? kin_rd.vel_long : '0;
         rsp_ff.vel_lat_code   <= slot_ok_ff ? kin_rd.vel_lat : '0;
         rsp_ff.rcs_code       <= slot_ok_ff ? kin_rd.rcs : '0;
         rsp_ff.meas_status    <= slot_ok_ff ? meas_rd : '0;
         rsp_ff.object_class   <= hold_ff.object_class;
         rsp_ff.orient_code    <= hold_ff.orient_code;
         rsp_ff.length_code    <= hold_ff.length_code;
         rsp_ff.width_code     <= hold_ff.width_code;
      end
   end

   assign kin_rd   = kin_entry_type'(kin_rd_bits);
   assign rsp_word = rsp_ff;

   rofd_ram #(
      .WIDTH (KIN_BITS),
      .DEPTH (OBJECT_SLOTS)
   ) u_kin_ram (
      .clock   (clock),
      .wr_en   (kin_we),
      .wr_addr (wr_slot),
      .wr_data (kin_wr_bits),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .rd_data (kin_rd_bits)
   );

   rofd_ram #(
      .WIDTH (3),
      .DEPTH (OBJECT_SLOTS)
   ) u_meas_ram (
      .clock   (clock),
      .wr_en   (meas_we),
      .wr_addr (wr_slot),
      .wr_data (meas_wr),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .rd_data (meas_rd)
   );

endmodule

// ===== design/radar_object_frame_decoder_core.sv =====
// radar object frame decoder top level: front end, command queue, table back end
// Takes one CAN frame word per cycle while the four-entry command queue has room
// (identifier 1547 general, 1548 quality, 1549 extended, anything else taken and
// dropped), so the input keeps flowing while a result waits. General and quality
// frames store raw kinematic codes and the decoded measurement state per object
// slot; each is handled in the back end's idle state. An extended frame reads both object
// tables through their registered read port and takes the back end through its read
// and send states: its result word is registered in the read state, is valid in the
// send state and stays there while the result side stalls. After reset the back end
// zeroes both tables, walking every object slot once; frames taken meanwhile wait
// in the queue and the input stalls once four are waiting. Results are raw codes
// with no physical scaling.
module radar_object_frame_decoder_core import rofd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   queue_status_type q_stat;
   logic             push, pop;
   cmd_type          cmd_in, cmd_head;

   rofd_front u_front (
      .req_valid (req_valid),
      .req_word  (req_word),
      .q_stat    (q_stat),
      .req_stall (req_stall),
      .push      (push),
      .cmd       (cmd_in)
   );

   rofd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .cmd_in  (cmd_in),
      .pop     (pop),
      .cmd_out (cmd_head),
      .q_stat  (q_stat)
   );

   rofd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head      (cmd_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // a known frame taken at the input is in the queue on the next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_word.frame_ident == ID_GENERAL || req_word.frame_ident == ID_QUALITY ||
       req_word.frame_ident == ID_EXTENDED)
      |=> !q_stat.empty)
      else $error("accepted frame did not reach the command queue");

   // a result only rises after a command left the queue and passed the read state
   a_rsp_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!q_stat.empty, 2))
      else $error("result word raised without a queued command");

   // the front never stalls while the queue has room
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !q_stat.full |-> !req_stall)
      else $error("input stalled with room in the queue");

endmodule
